>>> rtl/iap_pkg.sv
// Shared constants and types for the integer ALU with power unit.
`timescale 1ns / 1ps
`default_nettype none

package iap_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int OP_W           = 4;

  // Multiplier digit: full width up to this size, narrow digits above it.
  localparam int MUL_DIGIT_MAX  = 32;
  localparam int MUL_DIGIT_WIDE = 16;

  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV = 4'd3;
  localparam logic [OP_W-1:0] OP_MOD = 4'd4;
  localparam logic [OP_W-1:0] OP_POW = 4'd5;
  localparam logic [OP_W-1:0] OP_AND = 4'd6;
  localparam logic [OP_W-1:0] OP_XOR = 4'd7;
  localparam logic [OP_W-1:0] OP_OR  = 4'd8;
  localparam logic [OP_W-1:0] OP_ABS = 4'd9;
  localparam logic [OP_W-1:0] OP_NEG = 4'd10;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic pow_round;
    logic div_step;
    logic finish;
  } iap_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic b_neg;
    logic expo_zero;
  } iap_sts_t;

endpackage

`default_nettype wire

>>> rtl/iap_if.sv
// Request and response channel interfaces of the integer ALU with power unit.
`timescale 1ns / 1ps
`default_nettype none

interface iap_req_if import iap_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [OP_W-1:0]              operation;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input operation, input operand_a, input operand_b,
                output ready);
endinterface

interface iap_rsp_if import iap_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_value;
  logic                         error_code;

  modport source (output valid, output result_value, output error_code, input ready);
  modport sink (input valid, input result_value, input error_code, output ready);
endinterface

`default_nettype wire

>>> rtl/integer_alu_with_power_unit.sv
// Top level of the integer ALU with power unit.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates one two's complement operation per request: add, sub, mul, truncating div,
// mod with the dividend's sign, power, and, xor, or, abs and negate, all wrapping at
// DATA_WIDTH bits; div or mod by zero returns 0 with error_code set, a negative exponent
// returns 0. One request is worked on at a time; the next is taken as soon as the result
// sits in the output register, even if that result has not yet been taken. Div and mod
// do one radix-2 restoring step per cycle and skip the steps with a zero divisor. Power
// is done by the two multiplier lanes, which do one square-and-multiply round together
// per bit of the exponent; the lanes work in digits, full width up to 32 bits and 16 bits
// wide above.
module integer_alu_with_power_unit import iap_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  iap_req_if.sink   req,
  iap_rsp_if.source rsp
);

  iap_cmd_t cmd;
  iap_sts_t sts;

  iap_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_op     (req.operation),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iap_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk   (clk),
    .cmd   (cmd),
    .sts   (sts),
    .in_op (req.operation),
    .in_a  (req.operand_a),
    .in_b  (req.operand_b),
    .res   (rsp.result_value),
    .err   (rsp.error_code)
  );

endmodule

`default_nettype wire

>>> rtl/iap_ctrl.sv
// Sequencing controller of the integer ALU with power unit.
`timescale 1ns / 1ps
`default_nettype none

module iap_ctrl import iap_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  iap_sts_t        sts,
  output iap_cmd_t        cmd
);

  localparam int DIGIT = (DATA_WIDTH <= MUL_DIGIT_MAX) ? DATA_WIDTH : MUL_DIGIT_WIDE;
  localparam int NDIG  = (DATA_WIDTH + DIGIT - 1) / DIGIT;
  localparam int DIG_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {IDLE, MUL, POW, DIV, FIN} state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [DIG_W-1:0]   dig, dig_next;
  logic               out_valid_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    dig_next       = dig;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          dig_next = '0;
          if (in_op == OP_MUL) begin
            state_next = (NDIG > 1) ? MUL : FIN;
          end else if (in_op == OP_POW) begin
            state_next = POW;
          end else if (in_op inside {OP_DIV, OP_MOD}) begin
            state_next = DIV;
          end else begin
            state_next = FIN;
          end
        end
      end
      MUL: begin
        cmd.mul_step = 1'b1;
        dig_next     = dig + 1'b1;
        if (dig == DIG_W'(NDIG - 2)) begin
          state_next = FIN;
        end
      end
      POW: begin
        if (sts.b_neg || sts.expo_zero) begin
          state_next = FIN;
        end else if (dig == DIG_W'(NDIG - 1)) begin
          cmd.pow_round = 1'b1;
          dig_next      = '0;
        end else begin
          cmd.mul_step = 1'b1;
          dig_next     = dig + 1'b1;
        end
      end
      DIV: begin
        if (sts.b_zero) begin
          state_next = FIN;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next     = cnt + 1'b1;
          if (cnt == CNT_W'(DATA_WIDTH - 1)) begin
            state_next = FIN;
          end
        end
      end
      FIN: begin
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      dig       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      dig       <= dig_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/iap_dp.sv
// Datapath of the integer ALU with power unit: operands, two multiplier lanes, divider.
`timescale 1ns / 1ps
`default_nettype none

module iap_dp import iap_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  iap_cmd_t              cmd,
  output iap_sts_t              sts,
  input  logic [OP_W-1:0]       in_op,
  input  logic [DATA_WIDTH-1:0] in_a,
  input  logic [DATA_WIDTH-1:0] in_b,
  output logic [DATA_WIDTH-1:0] res,
  output logic                  err
);

  localparam int W     = DATA_WIDTH;
  localparam int DIGIT = (W <= MUL_DIGIT_MAX) ? W : MUL_DIGIT_WIDE;
  localparam int NDIG  = (W + DIGIT - 1) / DIGIT;
  localparam int MPW   = NDIG * DIGIT;

  logic [OP_W-1:0] op_r;
  logic [W-1:0]    a_r, b_r;
  logic [W-1:0]    acc, expo;
  logic [W-1:0]    mc1, mc2, sum1, sum2;
  logic [MPW-1:0]  mp1, mp2;
  logic [W-1:0]    rem, quo, dvs;

  logic [W+DIGIT-1:0] p1, p2;
  logic [W-1:0]       s1, s2, acc_upd;
  logic [W-1:0]       sh;
  logic [W:0]         diff;
  logic [W-1:0]       abs_a_in, abs_b_in;
  logic               is_mul_in;
  logic               a_neg, b_neg;
  logic [W-1:0]       res_next;
  logic               err_next;

  assign is_mul_in = (in_op == OP_MUL);
  assign abs_a_in  = in_a[W-1] ? ('0 - in_a) : in_a;
  assign abs_b_in  = in_b[W-1] ? ('0 - in_b) : in_b;

  assign p1      = mc1 * mp1[DIGIT-1:0];
  assign p2      = mc2 * mp2[DIGIT-1:0];
  assign s1      = sum1 + p1[W-1:0];
  assign s2      = sum2 + p2[W-1:0];
  assign acc_upd = expo[0] ? s1 : acc;

  assign sh   = {rem[W-2:0], quo[W-1]};
  assign diff = {1'b0, sh} - {1'b0, dvs};

  assign a_neg = a_r[W-1];
  assign b_neg = b_r[W-1];

  assign sts.b_zero    = (b_r == '0);
  assign sts.b_neg     = b_neg;
  assign sts.expo_zero = (expo == '0);

  always_comb begin
    res_next = '0;
    err_next = (op_r inside {OP_DIV, OP_MOD}) && (b_r == '0);
    case (op_r)
      OP_ADD: res_next = a_r + b_r;
      OP_SUB: res_next = a_r - b_r;
      OP_MUL: res_next = s1;
      OP_DIV: res_next = err_next ? '0 : ((a_neg ^ b_neg) ? ('0 - quo) : quo);
      OP_MOD: res_next = err_next ? '0 : (a_neg ? ('0 - rem) : rem);
      OP_POW: res_next = b_neg ? '0 : acc;
      OP_AND: res_next = a_r & b_r;
      OP_XOR: res_next = a_r ^ b_r;
      OP_OR:  res_next = a_r | b_r;
      OP_ABS: res_next = a_neg ? ('0 - a_r) : a_r;
      OP_NEG: res_next = '0 - a_r;
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      a_r  <= in_a;
      b_r  <= in_b;
      acc  <= W'(1);
      expo <= in_b;
      mc1  <= is_mul_in ? in_a : W'(1);
      mp1  <= MPW'(is_mul_in ? in_b : in_a);
      sum1 <= '0;
      mc2  <= in_a;
      mp2  <= MPW'(in_a);
      sum2 <= '0;
      rem  <= '0;
      quo  <= abs_a_in;
      dvs  <= abs_b_in;
    end
    if (cmd.mul_step) begin
      sum1 <= s1;
      sum2 <= s2;
      mc1  <= mc1 << DIGIT;
      mc2  <= mc2 << DIGIT;
      mp1  <= mp1 >> DIGIT;
      mp2  <= mp2 >> DIGIT;
    end
    if (cmd.pow_round) begin
      acc  <= acc_upd;
      expo <= expo >> 1;
      mc1  <= acc_upd;
      mp1  <= MPW'(s2);
      sum1 <= '0;
      mc2  <= s2;
      mp2  <= MPW'(s2);
      sum2 <= '0;
    end
    if (cmd.div_step) begin
      rem <= diff[W] ? sh : diff[W-1:0];
      quo <= {quo[W-2:0], ~diff[W]};
    end
    if (cmd.finish) begin
      res <= res_next;
      err <= err_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/iap_chk.sv
// Port checker of the integer ALU with power unit and its bind.
`timescale 1ns / 1ps
`default_nettype none

module iap_chk import iap_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [DATA_WIDTH-1:0] rsp_result_value,
  input logic                  rsp_error_code
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_error_code))
    else $error("response changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_error_code |-> rsp_result_value == '0)
    else $error("error response with nonzero result");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

endmodule

bind integer_alu_with_power_unit iap_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_iap_chk (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_result_value (rsp.result_value),
  .rsp_error_code   (rsp.error_code)
);

`default_nettype wire
